// ===== hdl/merge_sort_engine_assert.svh =====
// ----------------------------------------------------------------------------
// merge_sort_engine_assert
// assertion macros shared by the merge sort engine
// ----------------------------------------------------------------------------
`ifndef MERGE_SORT_ENGINE_ASSERT_SVH
`define MERGE_SORT_ENGINE_ASSERT_SVH

// same-cycle implication
`define MSE_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("merge sort engine assertion failed");

// next-cycle implication
`define MSE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("merge sort engine assertion failed");

`endif

// ===== hdl/mse_pkg.sv =====
// ----------------------------------------------------------------------------
// mse_pkg
// types and constants of the merge sort engine
// ----------------------------------------------------------------------------
package mse_pkg;

  localparam int VAL_W = 32;

  typedef struct packed {
    logic signed [VAL_W-1:0] value;
    logic                    last;
  } in_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] sorted_value;
    logic                    final_res;
    logic                    overflow;
  } res_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PASS,
    S_RUN,
    S_MRG_RD,
    S_MRG_WR,
    S_OUT
  } ctrl_state_t;

  typedef struct packed {
    logic load;
    logic pass_init;
    logic run_init;
    logic run_setup;
    logic merge_wr;
    logic pass_next;
    logic out_init;
    logic out_rd;
    logic clear;
  } cmd_t;

  typedef struct packed {
    logic pass_done;
    logic runs_done;
    logic run_last;
    logic out_last;
  } sts_t;

endpackage

// ===== hdl/merge_sort_engine.sv =====
// ----------------------------------------------------------------------------
// merge_sort_engine
// stable ascending sort of up to DEPTH signed values, bottom-up merge passes
// ----------------------------------------------------------------------------
// load: requests are taken while idle; the request marked last starts the sort
// sort: ceil(log2 n) passes, each a read state and a write state per element
//   (merge step on the registered-read ram pair), then the readout starts
// readout: n results, one result per cycle, back to back, cannot be stalled;
//   busy stays high until the next to last result
// synchronous reset clears the count and the flag
// ----------------------------------------------------------------------------
`include "merge_sort_engine_assert.svh"

module merge_sort_engine #(
  parameter int DEPTH = 64
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  mse_pkg::in_t  item,
  output logic          strobe,
  output mse_pkg::res_t result
);

  mse_pkg::cmd_t cmd;
  mse_pkg::sts_t sts;

  mse_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .last  (item.last),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  mse_datapath #(.DEPTH(DEPTH)) u_datapath (
    .clk    (clk),
    .rst    (rst),
    .item   (item),
    .cmd    (cmd),
    .sts    (sts),
    .result (result),
    .strobe (strobe)
  );

  `MSE_ASSERT_NEXT(a_run_contiguous, strobe && !result.final_res, strobe)
  `MSE_ASSERT_NEXT(a_gap_after_final, strobe && result.final_res, !strobe)
  `MSE_ASSERT_SAME(a_busy_in_run, strobe && !result.final_res, busy)
  `MSE_ASSERT_NEXT(a_last_starts_sort, start && !busy && item.last, busy)

endmodule

// ===== hdl/mse_ram.sv =====
// ----------------------------------------------------------------------------
// mse_ram
// generic ram, one write port and two registered read ports
// ----------------------------------------------------------------------------
module mse_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr_a,
  input  logic [AW-1:0]    raddr_b,
  output logic [WIDTH-1:0] rdata_a,
  output logic [WIDTH-1:0] rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

// ===== hdl/mse_datapath.sv =====
// ----------------------------------------------------------------------------
// mse_datapath
// element stores, run indices and merge compare of the merge sort engine
// ----------------------------------------------------------------------------
module mse_datapath #(
  parameter int DEPTH = 64
) (
  input  logic          clk,
  input  logic          rst,
  input  mse_pkg::in_t  item,
  input  mse_pkg::cmd_t cmd,
  output mse_pkg::sts_t sts,
  output mse_pkg::res_t result,
  output logic          strobe
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int LW = CW + 1;

  logic [CW-1:0] count;
  logic          dropped;
  logic [LW-1:0] w, lo, mid, hi, a, b, k;
  logic          sel;
  logic          final_r;
  logic          ovf_r;

  logic [LW-1:0] n, mid_c, hi_c, lo_w, mid_w;
  logic          room;
  logic          take_a;
  logic signed [mse_pkg::VAL_W-1:0] rd0_a, rd0_b, rd1_a, rd1_b;
  logic signed [mse_pkg::VAL_W-1:0] src_a, src_b, merge_val;
  logic          we0, we1;
  logic [AW-1:0] waddr0, raddr_a, raddr_b;
  logic signed [mse_pkg::VAL_W-1:0] wdata0;

  assign n     = LW'(count);
  assign room  = count < CW'(DEPTH);
  assign lo_w  = lo + w;
  assign mid_c = (lo_w > n) ? n : lo_w;
  assign mid_w = mid_c + w;
  assign hi_c  = (mid_w > n) ? n : mid_w;

  assign src_a     = sel ? rd1_a : rd0_a;
  assign src_b     = sel ? rd1_b : rd0_b;
  assign take_a    = (b >= hi) || ((a < mid) && (src_a <= src_b));
  assign merge_val = take_a ? src_a : src_b;

  assign we0     = (cmd.load && room) || (cmd.merge_wr && sel);
  assign waddr0  = cmd.load ? count[AW-1:0] : k[AW-1:0];
  assign wdata0  = cmd.load ? item.value : merge_val;
  assign we1     = cmd.merge_wr && !sel;
  assign raddr_a = cmd.out_rd ? k[AW-1:0] : a[AW-1:0];
  assign raddr_b = b[AW-1:0];

  mse_ram #(.WIDTH(mse_pkg::VAL_W), .DEPTH(DEPTH)) u_ram0 (
    .clk     (clk),
    .we      (we0),
    .waddr   (waddr0),
    .wdata   (wdata0),
    .raddr_a (raddr_a),
    .raddr_b (raddr_b),
    .rdata_a (rd0_a),
    .rdata_b (rd0_b)
  );

  mse_ram #(.WIDTH(mse_pkg::VAL_W), .DEPTH(DEPTH)) u_ram1 (
    .clk     (clk),
    .we      (we1),
    .waddr   (k[AW-1:0]),
    .wdata   (merge_val),
    .raddr_a (raddr_a),
    .raddr_b (raddr_b),
    .rdata_a (rd1_a),
    .rdata_b (rd1_b)
  );

  assign sts.pass_done = w >= n;
  assign sts.runs_done = lo >= n;
  assign sts.run_last  = (k + LW'(1)) >= hi;
  assign sts.out_last  = (k + LW'(1)) == n;

  always_ff @(posedge clk) begin
    if (rst) begin
      count   <= '0;
      dropped <= 1'b0;
      strobe  <= 1'b0;
    end else begin
      strobe <= cmd.out_rd;
      if (cmd.load) begin
        if (room) begin
          count <= count + CW'(1);
        end else begin
          dropped <= 1'b1;
        end
      end
      if (cmd.clear) begin
        count   <= '0;
        dropped <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.pass_init) begin
      w   <= LW'(1);
      sel <= 1'b0;
    end
    if (cmd.run_init) begin
      lo <= '0;
    end
    if (cmd.run_setup) begin
      mid <= mid_c;
      hi  <= hi_c;
      a   <= lo;
      b   <= mid_c;
      k   <= lo;
    end
    if (cmd.merge_wr) begin
      k <= k + LW'(1);
      if (take_a) begin
        a <= a + LW'(1);
      end else begin
        b <= b + LW'(1);
      end
      if (sts.run_last) begin
        lo <= hi;
      end
    end
    if (cmd.pass_next) begin
      w   <= w << 1;
      sel <= ~sel;
    end
    if (cmd.out_init) begin
      k <= '0;
    end
    if (cmd.out_rd) begin
      k <= k + LW'(1);
    end
    final_r <= cmd.out_rd && sts.out_last;
    ovf_r   <= dropped;
  end

  assign result.sorted_value = sel ? rd1_a : rd0_a;
  assign result.final_res    = final_r;
  assign result.overflow     = ovf_r;

endmodule

// ===== hdl/mse_ctrl.sv =====
// ----------------------------------------------------------------------------
// mse_ctrl
// sequencer for load, merge passes and readout of the merge sort engine
// ----------------------------------------------------------------------------
module mse_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic          last,
  input  mse_pkg::sts_t sts,
  output mse_pkg::cmd_t cmd,
  output logic          busy
);

  mse_pkg::ctrl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mse_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    busy       = 1'b1;
    unique case (state)
      mse_pkg::S_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.load = 1'b1;
          if (last) begin
            cmd.pass_init = 1'b1;
            state_next    = mse_pkg::S_PASS;
          end
        end
      end
      mse_pkg::S_PASS: begin
        if (sts.pass_done) begin
          cmd.out_init = 1'b1;
          state_next   = mse_pkg::S_OUT;
        end else begin
          cmd.run_init = 1'b1;
          state_next   = mse_pkg::S_RUN;
        end
      end
      mse_pkg::S_RUN: begin
        if (sts.runs_done) begin
          cmd.pass_next = 1'b1;
          state_next    = mse_pkg::S_PASS;
        end else begin
          cmd.run_setup = 1'b1;
          state_next    = mse_pkg::S_MRG_RD;
        end
      end
      mse_pkg::S_MRG_RD: begin
        state_next = mse_pkg::S_MRG_WR;
      end
      mse_pkg::S_MRG_WR: begin
        cmd.merge_wr = 1'b1;
        state_next   = sts.run_last ? mse_pkg::S_RUN : mse_pkg::S_MRG_RD;
      end
      mse_pkg::S_OUT: begin
        cmd.out_rd = 1'b1;
        if (sts.out_last) begin
          cmd.clear  = 1'b1;
          state_next = mse_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = mse_pkg::S_IDLE;
      end
    endcase
  end

endmodule
